// File: hw/rtl/fpss_pkg.sv
// shared types and constants for the farthest-point seed selector
package fpss_pkg;

    localparam int MAX_POINTS_DEF    = 1024;
    localparam int DIM_DEF           = 3;
    localparam int COORD_BITS_DEF    = 16;
    localparam int MAX_CENTROIDS_DEF = 64;
    localparam logic [6:0] NUM_CENT_RESET = 7'd8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EMIT0,
        ST_SCAN,
        ST_EMIT,
        ST_WAIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_wr;
        logic first_pass;
        logic scan_start;
        logic emit_fetch;
        logic run_done;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_busy;
        logic fetch_done;
    } dp_stat_t;

endpackage

// File: hw/rtl/fpss_ram.sv
// generic single-port-write, registered-read memory
module fpss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/fpss_datapath.sv
// point and distance stores, distance pipeline and farthest-point search
module fpss_datapath #(
    parameter int MAX_POINTS = fpss_pkg::MAX_POINTS_DEF,
    parameter int DIM        = fpss_pkg::DIM_DEF,
    parameter int COORD_BITS = fpss_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpss_pkg::dp_cmd_t               cmd,
    output fpss_pkg::dp_stat_t              stat,
    input  logic signed [COORD_BITS-1:0]    in_x,
    input  logic signed [COORD_BITS-1:0]    in_y,
    input  logic signed [COORD_BITS-1:0]    in_z,
    output logic [$clog2(MAX_POINTS+1)-1:0] count,
    output logic                            ovf,
    output logic [$clog2(MAX_POINTS)-1:0]   chosen,
    output logic signed [COORD_BITS-1:0]    sel_x,
    output logic signed [COORD_BITS-1:0]    sel_y,
    output logic signed [COORD_BITS-1:0]    sel_z
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 3 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 4;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    // point memory
    logic          p_we;
    logic [AW-1:0] p_waddr, p_raddr;
    logic [PW-1:0] p_wdata, p_rdata;

    // distance memory
    logic          d_we;
    logic [AW-1:0] d_waddr, d_raddr;
    logic [DW-1:0] d_wdata, d_rdata;

    // scan pipeline
    logic [CW-1:0] rd_idx_reg;
    logic          rd_act_reg;
    logic          s1_v_reg, s2_v_reg, s3_v_reg;
    logic [AW-1:0] s1_i_reg, s2_i_reg, s3_i_reg;
    logic          first_reg;
    logic signed [COORD_BITS:0] dx_reg, dy_reg, dz_reg;
    logic [2*COORD_BITS+1:0]    qx_reg, qy_reg, qz_reg;
    logic [DW-1:0] best_reg;
    logic [AW-1:0] chosen_reg;
    logic          seen_reg;
    logic [1:0]    fetch_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;

    logic signed [COORD_BITS-1:0] px, py, pz;
    logic [DW-1:0] dnew, dmin;

    assign count = count_reg;
    assign ovf   = ovf_reg;
    assign chosen = chosen_reg;
    assign sel_x = cx_reg;
    assign sel_y = cy_reg;
    assign sel_z = cz_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load_wr)
        begin
            if (count_reg == CW'(MAX_POINTS))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.run_done)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign p_we    = cmd.load_wr && (count_reg != CW'(MAX_POINTS));
    assign p_waddr = count_reg[AW-1:0];
    assign p_wdata = {(DIM >= 3) ? in_z : {COORD_BITS{1'b0}}, in_y, in_x};
    // the first centroid is always point 0
    assign p_raddr = cmd.emit_fetch ? (cmd.first_pass ? '0 : chosen_reg)
                                    : rd_idx_reg[AW-1:0];

    fpss_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign d_raddr = rd_idx_reg[AW-1:0];

    fpss_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_dist (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    assign px = p_rdata[COORD_BITS-1:0];
    assign py = p_rdata[2*COORD_BITS-1:COORD_BITS];
    assign pz = p_rdata[3*COORD_BITS-1:2*COORD_BITS];

    // stage 3: sum and compare with the stored nearest distance
    logic [DW-1:0] dist_rd_reg;
    logic [DW-1:0] dist_old_reg;
    assign dnew = DW'(qx_reg) + DW'(qy_reg) + DW'(qz_reg);
    assign dmin = (first_reg || dnew < dist_old_reg) ? dnew : dist_old_reg;
    assign d_we    = s3_v_reg;
    assign d_waddr = s3_i_reg;
    assign d_wdata = dmin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_act_reg <= 1'b0;
            rd_idx_reg <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            fetch_reg  <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                rd_act_reg <= 1'b1;
                rd_idx_reg <= '0;
            end
            else if (rd_act_reg)
            begin
                if (rd_idx_reg + CW'(1) >= count_reg)
                begin
                    rd_act_reg <= 1'b0;
                end
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            s1_v_reg  <= rd_act_reg;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            fetch_reg <= {fetch_reg[0], cmd.emit_fetch};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_i_reg <= rd_idx_reg[AW-1:0];
        s2_i_reg <= s1_i_reg;
        s3_i_reg <= s2_i_reg;
        if (cmd.scan_start)
        begin
            first_reg <= cmd.first_pass;
            seen_reg  <= 1'b0;
        end
        // stage 1: differences against the current centroid
        dx_reg <= (COORD_BITS+1)'(px) - (COORD_BITS+1)'(cx_reg);
        dy_reg <= (COORD_BITS+1)'(py) - (COORD_BITS+1)'(cy_reg);
        dz_reg <= (COORD_BITS+1)'(pz) - (COORD_BITS+1)'(cz_reg);
        // stage 2: squares
        qx_reg <= (2*COORD_BITS+2)'(dx_reg * dx_reg);
        qy_reg <= (2*COORD_BITS+2)'(dy_reg * dy_reg);
        qz_reg <= (2*COORD_BITS+2)'(dz_reg * dz_reg);
        // stored distance kept in step with the squares
        dist_rd_reg  <= d_rdata;
        dist_old_reg <= dist_rd_reg;
        // farthest search on the updated distances, strict > keeps lowest index
        if (s3_v_reg)
        begin
            seen_reg <= 1'b1;
            if (!seen_reg || dmin > best_reg)
            begin
                best_reg   <= dmin;
                chosen_reg <= s3_i_reg;
            end
        end
        if (cmd.emit_fetch && cmd.first_pass)
        begin
            chosen_reg <= '0;
        end
        if (fetch_reg[0])
        begin
            cx_reg <= px;
            cy_reg <= py;
            cz_reg <= pz;
        end
    end

    assign stat.scan_busy  = rd_act_reg | s1_v_reg | s2_v_reg | s3_v_reg;
    assign stat.fetch_done = fetch_reg[0];

endmodule

// File: hw/rtl/fpss_ctrl.sv
// sequencer for loading, distance passes and result output
module fpss_ctrl #(
    parameter int MAX_CENTROIDS = fpss_pkg::MAX_CENTROIDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               in_last,
    input  logic [6:0]         k_cfg,
    input  fpss_pkg::dp_stat_t stat,
    output fpss_pkg::dp_cmd_t  cmd,
    output logic               in_rdy,
    output logic               res_load,
    output logic [5:0]         res_id,
    output logic               res_last,
    input  logic               res_free
);

    fpss_pkg::ctrl_state_t state_reg, state_next;
    logic [6:0] k_reg, k_next;
    logic [6:0] c_reg, c_next;
    logic       pend_reg, pend_next;
    logic [6:0] k_sat;

    always_comb
    begin
        k_sat = k_cfg;
        if (k_cfg == 7'd0)
        begin
            k_sat = 7'd1;
        end
        else if (k_cfg > 7'(MAX_CENTROIDS))
        begin
            k_sat = 7'(MAX_CENTROIDS);
        end
    end

    assign res_id   = c_reg[5:0];
    assign res_last = (c_reg + 7'd1 == k_reg);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_rdy     = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            fpss_pkg::ST_LOAD:
            begin
                in_rdy      = 1'b1;
                cmd.load_wr = in_fire;
                if (in_fire && in_last)
                begin
                    k_next     = k_sat;
                    c_next     = '0;
                    pend_next  = 1'b0;
                    state_next = fpss_pkg::ST_EMIT0;
                end
            end
            // first centroid is point 0: fetch it, then run the first pass
            fpss_pkg::ST_EMIT0:
            begin
                if (!pend_reg)
                begin
                    cmd.emit_fetch = 1'b1;
                    cmd.first_pass = 1'b1;
                    pend_next      = 1'b1;
                end
                else if (stat.fetch_done)
                begin
                    pend_next  = 1'b0;
                    state_next = fpss_pkg::ST_EMIT;
                end
            end
            fpss_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    res_load = 1'b1;
                    if (res_last)
                    begin
                        cmd.run_done = 1'b1;
                        state_next   = fpss_pkg::ST_WAIT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.first_pass = (c_reg == 7'd0);
                        state_next     = fpss_pkg::ST_SCAN;
                    end
                end
            end
            fpss_pkg::ST_SCAN:
            begin
                if (!stat.scan_busy && !pend_reg)
                begin
                    cmd.emit_fetch = 1'b1;
                    pend_next      = 1'b1;
                end
                else if (pend_reg && stat.fetch_done)
                begin
                    pend_next  = 1'b0;
                    c_next     = c_reg + 7'd1;
                    state_next = fpss_pkg::ST_EMIT;
                end
            end
            fpss_pkg::ST_WAIT:
            begin
                if (res_free)
                begin
                    state_next = fpss_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = fpss_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpss_pkg::ST_LOAD;
            k_reg     <= 7'd1;
            c_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            pend_reg  <= pend_next;
        end
    end

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_rdy |-> state_reg == fpss_pkg::ST_LOAD)
        else $error("input taken outside load");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> c_reg < k_reg)
        else $error("centroid count overrun");
    a_scan_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> state_reg == fpss_pkg::ST_SCAN)
        else $error("scan started without scan state");

endmodule

// File: hw/rtl/farthest_point_seed_select_core.sv
// Farthest-point seed selector: points load at one word per cycle into a point
// memory (capacity MAX_POINTS, extra points dropped and flagged). The word with
// last_point set starts selection of num_centroids centroids (0 read as 1,
// saturated at MAX_CENTROIDS). Centroid 0 is point 0; each later one costs one
// pass over all N stored points through a four-stage distance pipeline with a
// single read port on each store, plus a point fetch. No input word is taken
// until the last centroid word has been handed over.
module farthest_point_seed_select_core #(
    parameter int MAX_POINTS    = fpss_pkg::MAX_POINTS_DEF,
    parameter int DIM           = fpss_pkg::DIM_DEF,
    parameter int COORD_BITS    = fpss_pkg::COORD_BITS_DEF,
    parameter int MAX_CENTROIDS = fpss_pkg::MAX_CENTROIDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [6:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic signed [COORD_BITS-1:0]  coord_z,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [5:0]                    centroid_id,
    output logic [$clog2(MAX_POINTS)-1:0] point_index,
    output logic signed [COORD_BITS-1:0]  cent_x,
    output logic signed [COORD_BITS-1:0]  cent_y,
    output logic signed [COORD_BITS-1:0]  cent_z,
    output logic                          overflowed,
    output logic                          last_centroid
);

    fpss_pkg::dp_cmd_t  cmd;
    fpss_pkg::dp_stat_t stat;
    logic [6:0] k_cfg_reg;
    logic       in_rdy, res_load, res_last, in_fire, res_free;
    logic [5:0] res_id;
    logic [$clog2(MAX_POINTS+1)-1:0] count;
    logic       ovf;
    logic [$clog2(MAX_POINTS)-1:0] chosen;
    logic signed [COORD_BITS-1:0] sx, sy, sz;
    logic       ov_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg <= fpss_pkg::NUM_CENT_RESET;
        end
        else if (cfg_valid)
        begin
            k_cfg_reg <= cfg_data;
        end
    end

    assign in_ready = in_rdy;
    assign in_fire  = in_valid && in_rdy;
    assign res_free = !ov_reg || out_ready;

    fpss_ctrl #(.MAX_CENTROIDS(MAX_CENTROIDS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(last_point),
        .k_cfg(k_cfg_reg), .stat(stat), .cmd(cmd), .in_rdy(in_rdy),
        .res_load(res_load), .res_id(res_id), .res_last(res_last),
        .res_free(res_free)
    );

    fpss_datapath #(.MAX_POINTS(MAX_POINTS), .DIM(DIM), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_x(coord_x), .in_y(coord_y), .in_z(coord_z),
        .count(count), .ovf(ovf), .chosen(chosen),
        .sel_x(sx), .sel_y(sy), .sel_z(sz)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (res_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            centroid_id   <= res_id;
            point_index   <= chosen;
            cent_x        <= sx;
            cent_y        <= sy;
            cent_z        <= sz;
            overflowed    <= ovf;
            last_centroid <= res_last;
        end
    end

    assign out_valid = ov_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count <= ($clog2(MAX_POINTS+1))'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word lost");

endmodule
